// ===== design/kms_pkg.sv =====
// kms_pkg: payload structs, opcodes, result kinds and scan modes for the
// keypad matrix scanner. No dependencies.
package kms_pkg;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] rows;
  } kms_in_t;

  typedef struct packed {
    logic [3:0] col_drive;
    logic [1:0] kind;
    logic [1:0] key_column;
    logic [1:0] key_row;
    logic       key_pressed;
    logic       last;
  } kms_out_t;

  // one key-change event offered by the change walker
  typedef struct packed {
    logic       valid;
    logic [1:0] column;
    logic [1:0] row;
    logic       pressed;
    logic       last;
  } kms_ev_t;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_POWER_DOWN = 2'd1;
  localparam logic [1:0] OP_WAKE_UP    = 2'd2;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_CHANGE  = 2'd1;
  localparam logic [1:0] KIND_WAKE    = 2'd2;
  localparam logic [1:0] KIND_STANDBY = 2'd3;

  localparam logic [15:0] INTERVAL_RESET = 16'd50;
  localparam logic [4:0]  MAX_EVENTS     = 5'd16;

  typedef enum logic [3:0] {
    M_SAMPLE  = 4'b0001,
    M_PARK    = 4'b0010,
    M_WATCH   = 4'b0100,
    M_DORMANT = 4'b1000
  } kms_mode_t;

  function automatic logic [2:0] popcount4(input logic [3:0] v);
    popcount4 = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
  endfunction

endpackage

// ===== design/kms_change_walker.sv =====
// kms_change_walker: steps through the key matrix one key per cycle, pausing
// on a changed key until the output slot is free, and offers each changed key as an event. Depends on kms_pkg.
module kms_change_walker import kms_pkg::*; #(
  parameter int COLUMNS = 4,
  parameter int ROWS    = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [4:0]              total,
  input  logic [COLUMNS-1:0][3:0] diff,
  input  logic [COLUMNS-1:0][3:0] snap,
  input  logic                    slot_free,
  output kms_ev_t                 ev,
  output logic                    busy
);

  localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RB  = (ROWS < 4) ? ROWS : 4;  // rows input is four bits
  localparam logic [1:0] LAST_ROW = 2'(RB - 1);

  logic [CIW-1:0] wc;
  logic [1:0]     wr;
  logic [4:0]     emitted;
  logic [4:0]     total_q;  // event count of this walk, held from start
  logic           hit;
  logic           step;
  logic           take;

  assign hit  = diff[wc][wr];
  assign take = busy && hit && slot_free;
  assign step = busy && (!hit || slot_free);

  always_comb begin
    ev.valid   = busy && hit;
    ev.column  = 2'(wc);
    ev.row     = wr;
    ev.pressed = snap[wc][wr];
    ev.last    = ((emitted + 5'd1) == total_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      wc      <= '0;
      wr      <= '0;
      emitted <= '0;
      total_q <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      wc      <= '0;
      wr      <= '0;
      emitted <= '0;
      total_q <= total;
    end else begin
      if (take) begin
        emitted <= emitted + 5'd1;
        if (ev.last) busy <= 1'b0;
      end
      if (step) begin
        if (wr == LAST_ROW) begin
          wr <= '0;
          wc <= wc + CIW'(1);
        end else begin
          wr <= wr + 2'd1;
        end
      end
    end
  end

endmodule

// ===== design/keypad_matrix_scanner.sv =====
// keypad_matrix_scanner: top level of the key matrix scanner.
// Depends on kms_pkg and kms_change_walker.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one transfer per tick with
//    a row sample, or a power-down / wake-up command.
//  - Output channel (out_valid/out_ready/out_data): every input gives one
//    or more results; the final one of an input carries last.
//  - Config channel (cfg_valid/cfg_ready/cfg_data): scan interval in ticks,
//    always ready; write it only while the block is idle.
// Timing: an ordinary input lands in the output register in the cycle
// after its transfer. The input transfer that samples the last column
// starts the change walker if the scan found changes; the walker visits
// one key per cycle, pausing on a changed key until the output slot is
// free, and the block takes no input until the walk's last event is out.
// Otherwise an input is taken each cycle the output slot is free.
// Reset: sampling mode at column 0, awake, key map all released, interval
// 50. A stalled receiver holds the output register and, through it, input.
module keypad_matrix_scanner import kms_pkg::*; #(
  parameter int COLUMNS = 4,
  parameter int ROWS    = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  kms_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output kms_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [CIW-1:0] LAST_COL = CIW'(COLUMNS - 1);
  localparam int ALL_COLS_I = ((1 << COLUMNS) - 1) & 15;
  localparam int ROW_MASK_I = ((1 << ROWS) - 1) & 15;
  localparam logic [3:0] ALL_COLS = 4'(ALL_COLS_I);
  localparam logic [3:0] ROW_MASK = 4'(ROW_MASK_I);

  // scan state
  kms_mode_t      mode, mode_next;
  logic [CIW-1:0] col, col_next;
  logic           awake, awake_next;
  logic [15:0]    interval_count, interval_count_next;
  logic [15:0]    scan_interval_ticks;

  // per-column row snapshot, its difference to the key map, and the map
  logic [COLUMNS-1:0][3:0] snap;
  logic [COLUMNS-1:0][3:0] diff;
  logic [COLUMNS-1:0][3:0] previous_keys;

  // running summaries of the scan in progress
  logic       any_acc, any_next;
  logic [5:0] cnt_acc, cnt_next;
  logic [4:0] total;

  logic       accept;
  logic       slot_free;
  logic       scan_end;
  logic       walk_start;
  logic       walk_busy;
  logic [3:0] rows_m;
  logic [3:0] diff_col;
  logic [1:0] kind;
  kms_ev_t    ev;

  function automatic logic [3:0] drive(input kms_mode_t m, input logic [CIW-1:0] c);
    case (m)
      M_SAMPLE: drive = 4'(8'(1) << c);
      M_PARK:   drive = 4'b0000;
      default:  drive = ALL_COLS;
    endcase
  endfunction

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = !walk_busy && slot_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign rows_m   = in_data.rows & ROW_MASK;
  assign diff_col = rows_m ^ previous_keys[col];
  assign any_next = (col == '0) ? (rows_m != 4'd0) : (any_acc || (rows_m != 4'd0));
  assign cnt_next = ((col == '0) ? 6'd0 : cnt_acc) + 6'(popcount4(diff_col));
  assign total    = (cnt_next > 6'd16) ? MAX_EVENTS : cnt_next[4:0];

  // next scan state for the accepted input
  always_comb begin
    mode_next           = mode;
    col_next            = col;
    awake_next          = awake;
    interval_count_next = interval_count;
    kind                = KIND_STATUS;
    scan_end            = 1'b0;
    if (accept) begin
      case (in_data.opcode)
        OP_TICK: begin
          case (mode)
            M_SAMPLE: begin
              if (col == LAST_COL) begin
                scan_end = 1'b1;
                if (any_next) begin
                  mode_next           = M_PARK;
                  interval_count_next = scan_interval_ticks;
                end else begin
                  mode_next = M_WATCH;
                end
              end else begin
                col_next = col + CIW'(1);
              end
            end
            M_PARK: begin
              // an interval of zero behaves like one
              if (interval_count <= 16'd1) begin
                interval_count_next = 16'd0;
                mode_next           = M_SAMPLE;
                col_next            = '0;
              end else begin
                interval_count_next = interval_count - 16'd1;
              end
            end
            M_WATCH: begin
              if (in_data.rows != 4'd0) begin
                if (awake) begin
                  mode_next = M_SAMPLE;
                  col_next  = '0;
                end else begin
                  mode_next = M_DORMANT;
                  kind      = KIND_WAKE;
                end
              end
            end
            default: ;
          endcase
        end
        OP_POWER_DOWN: begin
          awake_next = 1'b0;
          if (mode == M_WATCH || mode == M_DORMANT) kind = KIND_STANDBY;
        end
        OP_WAKE_UP: begin
          if (!awake) begin
            awake_next = 1'b1;
            mode_next  = M_SAMPLE;
            col_next   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // a scan end with changes hands over to the walker; else one result now
  assign walk_start = scan_end && (total != 5'd0);

  kms_change_walker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .total    (total),
    .diff     (diff),
    .snap     (snap),
    .slot_free(slot_free),
    .ev       (ev),
    .busy     (walk_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= M_SAMPLE;
      col                 <= '0;
      awake               <= 1'b1;
      interval_count      <= 16'd0;
      scan_interval_ticks <= INTERVAL_RESET;
      previous_keys       <= '0;
      out_valid           <= 1'b0;
    end else begin
      mode           <= mode_next;
      col            <= col_next;
      awake          <= awake_next;
      interval_count <= interval_count_next;
      if (cfg_valid && cfg_ready) scan_interval_ticks <= cfg_data;

      // key map takes the full snapshot at scan end
      if (scan_end) begin
        for (int c = 0; c < COLUMNS; c++) begin
          if (CIW'(c) == col) previous_keys[c] <= rows_m;
          else                previous_keys[c] <= snap[c] & ROW_MASK;
        end
      end

      if (accept && !walk_start) out_valid <= 1'b1;
      else if (ev.valid && slot_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_TICK && mode == M_SAMPLE) begin
      snap[col] <= in_data.rows;
      diff[col] <= diff_col;
      any_acc   <= any_next;
      cnt_acc   <= cnt_next;
    end
    if (accept && !walk_start) begin
      out_data.col_drive   <= drive(mode_next, col_next);
      out_data.kind        <= kind;
      out_data.key_column  <= 2'd0;
      out_data.key_row     <= 2'd0;
      out_data.key_pressed <= 1'b0;
      out_data.last        <= 1'b1;
    end else if (ev.valid && slot_free) begin
      out_data.col_drive   <= drive(mode, col);
      out_data.kind        <= KIND_CHANGE;
      out_data.key_column  <= ev.column;
      out_data.key_row     <= ev.row;
      out_data.key_pressed <= ev.pressed;
      out_data.last        <= ev.last;
    end
  end

endmodule

// ===== tb/sv/keypad_matrix_scanner_tb.sv =====
`timescale 1ns / 1ps
// keypad_matrix_scanner_tb: self-checking bench for the 4x4 key matrix scanner.
// Depends on kms_pkg and the keypad_matrix_scanner RTL, nothing else.
module keypad_matrix_scanner_tb;
  import kms_pkg::*;

  // opcode 3 has no meaning; the block must answer it with a plain status
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // cycles with no transfer on any channel before the run is abandoned;
  // the worst legal gap is a stalled receiver behind a 16-event scan end
  localparam int STALL_LIMIT = 5000;
  // settle time at the end: the change walker plus margin
  localparam int END_WAIT    = 40;
  localparam int MAX_SHOWN   = 10;
  localparam int PHASE_ITEMS = 77;

  // scanner state as seen from the pins, at the block's widths
  typedef struct packed {
    kms_mode_t       mode;
    logic [1:0]      column;
    logic [3:0][3:0] snap;       // row bits per column, this scan
    logic [3:0][3:0] held;       // key map from the last finished scan
    logic [15:0]     park_left;
    logic            awake;
    logic [15:0]     interval;
  } keypad_state_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  kms_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  kms_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  always #4 clk = ~clk;

  keypad_matrix_scanner u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // track_state follows the inputs the block has taken; plan_state runs
  // ahead over the queued items so the generator knows where the scan is
  keypad_state_t track_state;
  keypad_state_t plan_state;
  logic [3:0][3:0] key_target;   // key map the current planned scan presents

  kms_in_t     tick_queue[$];    // items waiting for the driver
  kms_out_t    event_queue[$];   // results the block still owes
  int unsigned src_idle_pct   = 0;
  int unsigned snk_stall_pct  = 0;
  int          mismatch_count = 0;
  int          stall_cycles   = 0;

  // Advance the scanner state by one input and build its results.
  // Returns the number of results written to ev.
  function automatic int scan_step(inout keypad_state_t s, input kms_in_t x,
                                   output kms_out_t ev [0:15]);
    int         n;
    int         c;
    int         r;
    logic       any_down;
    logic [1:0] kind;
    logic [3:0] drive;
    n        = 0;
    any_down = 1'b0;
    kind     = KIND_STATUS;
    for (c = 0; c < 16; c++) ev[c] = '0;
    case (x.opcode)
      OP_TICK: begin
        case (s.mode)
          M_SAMPLE: begin
            s.snap[s.column] = x.rows;
            if (s.column != 2'd3) begin
              s.column = s.column + 2'd1;
            end else begin
              // scan end: one event per changed key, column-major
              for (c = 0; c < 4; c++) begin
                for (r = 0; r < 4; r++) begin
                  if (s.snap[c][r] != s.held[c][r]) begin
                    ev[n].kind        = KIND_CHANGE;
                    ev[n].key_column  = 2'(c);
                    ev[n].key_row     = 2'(r);
                    ev[n].key_pressed = s.snap[c][r];
                    n++;
                  end
                end
                any_down |= |s.snap[c];
              end
              s.held = s.snap;
              if (any_down) begin
                s.mode      = M_PARK;
                s.park_left = s.interval;
              end else begin
                s.mode = M_WATCH;
              end
            end
          end
          M_PARK: begin
            // rows ignored; an interval of 0 acts as 1
            if (s.park_left <= 16'd1) begin
              s.park_left = '0;
              s.mode      = M_SAMPLE;
              s.column    = '0;
            end else begin
              s.park_left = s.park_left - 16'd1;
            end
          end
          M_WATCH: begin
            if (x.rows != 4'd0) begin
              if (s.awake) begin
                s.mode   = M_SAMPLE;
                s.column = '0;
              end else begin
                s.mode = M_DORMANT;
                kind   = KIND_WAKE;
              end
            end
          end
          default: ;   // dormant: rows ignored until woken
        endcase
      end
      OP_POWER_DOWN: begin
        s.awake = 1'b0;
        if (s.mode == M_WATCH || s.mode == M_DORMANT) kind = KIND_STANDBY;
      end
      OP_WAKE_UP: begin
        if (!s.awake) begin
          s.awake  = 1'b1;
          s.mode   = M_SAMPLE;
          s.column = '0;
        end
      end
      default: ;
    endcase
    case (s.mode)
      M_SAMPLE: drive = 4'd1 << s.column;
      M_PARK:   drive = 4'h0;
      default:  drive = 4'hF;
    endcase
    if (n == 0) begin
      ev[0].kind = kind;
      n = 1;
    end
    for (c = 0; c < n; c++) ev[c].col_drive = drive;
    ev[n-1].last = 1'b1;
    return n;
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [3:0] rows);
    kms_in_t  x;
    kms_out_t scratch [0:15];
    x.opcode = op;
    x.rows   = rows;
    void'(scan_step(plan_state, x, scratch));
    tick_queue.push_back(x);
  endtask

  // Mostly well-formed traffic shaped by the planned mode: full scans of a
  // chosen key map, parks that run out or get cut short by power-down and
  // wake-up, row activity in watch. A few percent is pure noise.
  task automatic queue_random_item();
    int roll;
    int sel;
    int c;
    int r;
    roll = $urandom_range(99);
    if (roll < 6) begin
      queue_item(2'($urandom_range(3)), 4'($urandom));
      return;
    end
    case (plan_state.mode)
      M_SAMPLE: begin
        if (plan_state.column == 2'd0) begin
          sel = $urandom_range(99);
          if (sel < 25) begin
            key_target = '0;                   // everything released
          end else if (sel < 45) begin
            key_target = plan_state.held;      // no change
          end else if (sel < 55) begin
            key_target = '1;                   // all sixteen down
          end else if (sel < 65) begin
            key_target = plan_state.held;      // one key toggles
            c = $urandom_range(3);
            r = $urandom_range(3);
            key_target[c][r] = ~key_target[c][r];
          end else begin
            for (c = 0; c < 4; c++) key_target[c] = 4'($urandom & $urandom);
          end
        end
        if (roll < 11) queue_item(OP_POWER_DOWN, 4'($urandom));
        else queue_item(OP_TICK, key_target[plan_state.column]);
      end
      M_PARK: begin
        // long intervals: escape through power-down then wake-up
        if (plan_state.park_left > 16'd12) begin
          if (plan_state.awake) queue_item(OP_POWER_DOWN, 4'($urandom));
          else queue_item(OP_WAKE_UP, 4'($urandom));
        end else begin
          queue_item(OP_TICK, 4'($urandom));
        end
      end
      M_WATCH: begin
        if (plan_state.awake) begin
          if (roll < 60) queue_item(OP_TICK, 4'($urandom_range(1, 15)));
          else if (roll < 85) queue_item(OP_TICK, 4'h0);
          else queue_item(OP_POWER_DOWN, 4'($urandom));
        end else begin
          if (roll < 45) queue_item(OP_TICK, 4'($urandom_range(1, 15)));
          else if (roll < 75) queue_item(OP_TICK, 4'h0);
          else queue_item(OP_WAKE_UP, 4'($urandom));
        end
      end
      default: begin
        if (roll < 50) queue_item(OP_WAKE_UP, 4'($urandom));
        else if (roll < 85) queue_item(OP_TICK, 4'($urandom));
        else queue_item(OP_POWER_DOWN, 4'($urandom));
      end
    endcase
  endtask

  // Wait until every queued item is taken and every result has come back.
  // Checks run at the edge, so they see pre-edge values: never early.
  task automatic drain_all();
    while (tick_queue.size() != 0 || in_valid || event_queue.size() != 0)
      @(posedge clk);
  endtask

  // Interval write; only called with the block idle, right after an edge.
  task automatic write_interval(input logic [15:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    track_state.interval = value;
    plan_state.interval  = value;
    cfg_valid <= 1'b0;
  endtask

  // Input driver: predicts on each transfer, then loads the next item
  // when the slot is free and the sender is not idling.
  always @(posedge clk) begin
    kms_out_t evs [0:15];
    int       n;
    int       k;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n = scan_step(track_state, in_data, evs);
        for (k = 0; k < n; k++) event_queue.push_back(evs[k]);
      end
      if (!in_valid || in_ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= tick_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Result monitor: every output transfer against the oldest expectation
  always @(posedge clk) begin
    kms_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (event_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result: drive %h kind %0d col %0d row %0d pressed %0d last %0d",
                   out_data.col_drive, out_data.kind, out_data.key_column,
                   out_data.key_row, out_data.key_pressed, out_data.last);
      end else begin
        want = event_queue.pop_front();
        if (out_data.col_drive   !== want.col_drive  ||
            out_data.kind        !== want.kind       ||
            out_data.key_column  !== want.key_column ||
            out_data.key_row     !== want.key_row    ||
            out_data.key_pressed !== want.key_pressed ||
            out_data.last        !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $write("mismatch: expected drive %h kind %0d col %0d row %0d pressed %0d last %0d",
                   want.col_drive, want.kind, want.key_column, want.key_row,
                   want.key_pressed, want.last);
            $display(", got drive %h kind %0d col %0d row %0d pressed %0d last %0d",
                     out_data.col_drive, out_data.kind, out_data.key_column,
                     out_data.key_row, out_data.key_pressed, out_data.last);
          end
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [15:0] setting;
    track_state          = '0;
    track_state.mode     = M_SAMPLE;
    track_state.awake    = 1'b1;
    track_state.interval = INTERVAL_RESET;
    plan_state           = track_state;
    key_target           = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed pass at the reset interval, no idling.
    // Full scan with every key down: sixteen press events, then parked.
    repeat (4) queue_item(OP_TICK, 4'hF);
    queue_item(OP_UNUSED, 4'h5);         // meaningless opcode, status only
    queue_item(OP_WAKE_UP, 4'h0);        // already awake: ignored
    queue_item(OP_POWER_DOWN, 4'hA);     // parked, so plain status
    queue_item(OP_WAKE_UP, 4'h0);        // powered down: rescan from column 0
    // everything released: sixteen release events, then watching rows
    repeat (4) queue_item(OP_TICK, 4'h0);
    queue_item(OP_TICK, 4'h0);           // quiet rows in watch
    queue_item(OP_POWER_DOWN, 4'h0);     // outside a scan: standby entered
    queue_item(OP_TICK, 4'h8);           // activity while down: wake request
    queue_item(OP_TICK, 4'hF);           // dormant, rows ignored
    queue_item(OP_POWER_DOWN, 4'h3);     // dormant: standby again
    queue_item(OP_WAKE_UP, 4'h0);        // scan restarts at column 0
    // power down in mid-scan; the scan goes on and a held key parks it
    queue_item(OP_TICK, 4'h0);
    queue_item(OP_POWER_DOWN, 4'h0);
    queue_item(OP_TICK, 4'h4);
    queue_item(OP_TICK, 4'h0);
    queue_item(OP_TICK, 4'h0);
    drain_all();

    // Random phases: interval extremes plus a few short settings, under
    // each back-pressure pattern in turn.
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 79; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 79; end
        default: begin src_idle_pct = 28; snk_stall_pct = 28; end
      endcase
      case (p)
        0:       setting = 16'd1;
        1:       setting = 16'hFFFF;
        2:       setting = 16'd2;
        3:       setting = 16'd3;
        4:       setting = 16'($urandom_range(4, 12));
        default: setting = 16'd1;
      endcase
      write_interval(setting);
      repeat (PHASE_ITEMS) queue_random_item();
      drain_all();
    end

    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
